### hdl/hof_pkg.sv
// Shared constants and types of the Hampel outlier filter.
`default_nettype none

package hof_pkg;

   // Window length used when the top level is not given another.
   localparam int WINDOW_DEFAULT = 16;

   // Flipping the sign bit orders signed readings as unsigned keys.
   localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

   // Reset value of the Q8.8 threshold scale (about 3 * 1.4826 * 256).
   localparam logic [15:0] SCALE_RESET = 16'd1139;

   // Register index of the threshold scale on the configuration port.
   localparam logic [0:0] REG_THRESHOLD_SCALE = 1'b0;

   typedef logic [31:0] key_type;

   // Absolute difference of two unsigned keys.
   function automatic key_type abs_diff(input key_type a, input key_type b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

### hdl/hof_if.sv
// Handshake interfaces for the reading and result channels.
`default_nettype none

interface hof_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] reading;

   modport source (output valid, output reading, input ready);
   modport sink   (input valid, input reading, output ready);
endinterface

interface hof_rsp_if;
   logic        valid;
   logic        ready;
   logic        checked;
   logic        is_outlier;
   logic [31:0] center_value;
   logic [31:0] window_median;
   logic [31:0] abs_deviation_median;
   logic [31:0] published_value;
   logic        updated;

   modport source (output valid, output checked, output is_outlier, output center_value,
                   output window_median, output abs_deviation_median,
                   output published_value, output updated, input ready);
   modport sink   (input valid, input checked, input is_outlier, input center_value,
                   input window_median, input abs_deviation_median,
                   input published_value, input updated, output ready);
endinterface

`default_nettype wire

### hdl/hof_sort_cell.sv
// One cell of the systolic insertion sorter: keeps the smaller key, passes the larger.
`default_nettype none

module hof_sort_cell
   import hof_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    clear,
   input  wire logic    in_valid,
   input  wire key_type in_key,
   output logic         out_valid,
   output key_type      out_key,
   output key_type      held_key
);

   logic    held_valid_ff, held_valid_in;
   key_type held_key_ff, held_key_in;
   logic    pass_valid_ff, pass_valid_in;
   key_type pass_key_ff, pass_key_in;

   // Insert the arriving key; the displaced or arriving larger key moves on.
   always_comb begin
      held_valid_in = held_valid_ff;
      held_key_in   = held_key_ff;
      pass_valid_in = 1'b0;
      pass_key_in   = in_key;
      if (clear) begin
         held_valid_in = 1'b0;
      end else if (in_valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_key_in   = in_key;
         end else if (in_key < held_key_ff) begin
            held_key_in   = in_key;
            pass_valid_in = 1'b1;
            pass_key_in   = held_key_ff;
         end else begin
            pass_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
      held_key_ff <= held_key_in;
      pass_key_ff <= pass_key_in;
   end

   assign out_valid = pass_valid_ff;
   assign out_key   = pass_key_ff;
   assign held_key  = held_key_ff;

endmodule

`default_nettype wire

### hdl/hof_sorter.sv
// Chain of sorter cells; after settling, cell k holds element k of the sorted keys.
`default_nettype none

module hof_sorter
   import hof_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    clear,
   input  wire logic    feed_valid,
   input  wire key_type feed_key,
   output key_type      sorted_key [WINDOW]
);

   logic    link_valid [WINDOW+1];
   key_type link_key   [WINDOW+1];

   assign link_valid[0] = feed_valid;
   assign link_key[0]   = feed_key;

   // Each cell hands its overflow key to the next one.
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      hof_sort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (clear),
         .in_valid  (link_valid[k]),
         .in_key    (link_key[k]),
         .out_valid (link_valid[k+1]),
         .out_key   (link_key[k+1]),
         .held_key  (sorted_key[k])
      );
   end

endmodule

`default_nettype wire

### hdl/hampel_outlier_filter.sv
// Top level of the Hampel outlier filter for meter readings.
//
// Readings enter on req_chan (valid/ready); one result per reading leaves on
// rsp_chan from an output register. The Q8.8 threshold scale is written over
// the csr_ APB port at byte address 0; pready is always high.
// While the window fills, a reading is stored and its result is offered in the
// cycle after the transfer. Once the window is full, a reading goes from its
// transfer to the transfer of its result through two passes of the sorter
// cell chain, each a feed phase and then a settle phase, for the median and
// then the MAD, then a multiply step, a compare step that loads the output
// register, and the offer of the result.
// One reading is processed at a time; req_chan.ready is high only while the
// block is idle and the output register is free or being emptied.
// If the receiver stalls, the result holds on rsp_chan and the next result
// waits in the compare step until the register frees.
// Reset empties the window, clears the published value to zero, sets the
// scale to its default and drops any pending result.
`default_nettype none

module hampel_outlier_filter
   import hof_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   hof_req_if.sink    req_chan,
   hof_rsp_if.source  rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CENTER   = WINDOW / 2;
   localparam int FILL_W   = $clog2(WINDOW + 1);
   localparam int SETTLE   = 2 * WINDOW;
   localparam int CNT_W    = $clog2(SETTLE + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SORT_VAL, ST_SORT_DEV, ST_MULT, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [15:0]        scale_ff;
   logic [31:0]        accepted_ff;
   key_type            win_ff [WINDOW];
   key_type            median_key_ff;
   key_type            mad_ff;
   key_type            dev_ff;
   logic [47:0]        prod_ff;
   key_type            sorted_key [WINDOW];

   logic        rsp_valid_ff, rsp_checked_ff, rsp_outlier_ff, rsp_updated_ff;
   logic [31:0] rsp_center_ff, rsp_median_ff, rsp_mad_ff, rsp_published_ff;

   logic    req_xfer, slot_free, feeding, sorter_clear, outlier;
   key_type feed_key, center_key;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_xfer = req_chan.valid && req_chan.ready;

   // Configuration port: single register, zero-wait.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_THRESHOLD_SCALE) ? {16'd0, scale_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == REG_THRESHOLD_SCALE) begin
         scale_ff <= csr_pwdata[15:0];
      end
   end

   // Sorter feed comes from the head of the window, which rotates while feeding.
   assign feeding = (state_ff == ST_SORT_VAL || state_ff == ST_SORT_DEV)
                    && (cnt_ff < CNT_W'(WINDOW));
   assign feed_key = (state_ff == ST_SORT_DEV)
                     ? abs_diff(win_ff[0] ^ SIGN_FLIP, median_key_ff)
                     : (win_ff[0] ^ SIGN_FLIP);
   assign sorter_clear = (state_ff == ST_IDLE)
                         || (state_ff == ST_SORT_VAL && cnt_ff == CNT_W'(SETTLE));

   hof_sorter #(.WINDOW(WINDOW)) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .clear      (sorter_clear),
      .feed_valid (feeding),
      .feed_key   (feed_key),
      .sorted_key (sorted_key)
   );

   // Window shift line: shift in on a transfer, rotate while feeding the sorter.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int k = 0; k < WINDOW - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[WINDOW-1] <= req_chan.reading;
      end else if (feeding) begin
         for (int k = 0; k < WINDOW - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[WINDOW-1] <= win_ff[0];
      end
   end

   assign center_key = win_ff[CENTER] ^ SIGN_FLIP;
   assign outlier = {8'd0, dev_ff, 8'd0} > prod_ff;

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         accepted_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (fill_ff < FILL_W'(WINDOW)) begin
                     fill_ff          <= fill_ff + FILL_W'(1);
                     rsp_valid_ff     <= 1'b1;
                     rsp_checked_ff   <= 1'b0;
                     rsp_outlier_ff   <= 1'b0;
                     rsp_center_ff    <= '0;
                     rsp_median_ff    <= '0;
                     rsp_mad_ff       <= '0;
                     rsp_published_ff <= accepted_ff;
                     rsp_updated_ff   <= 1'b0;
                  end else begin
                     cnt_ff   <= '0;
                     state_ff <= ST_SORT_VAL;
                  end
               end
            end
            ST_SORT_VAL: begin
               if (cnt_ff == CNT_W'(SETTLE)) begin
                  median_key_ff <= sorted_key[CENTER];
                  cnt_ff        <= '0;
                  state_ff      <= ST_SORT_DEV;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_SORT_DEV: begin
               if (cnt_ff == CNT_W'(SETTLE)) begin
                  mad_ff   <= sorted_key[CENTER];
                  state_ff <= ST_MULT;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_MULT: begin
               prod_ff  <= {16'd0, 32'(scale_ff)} * {16'd0, mad_ff};
               dev_ff   <= abs_diff(center_key, median_key_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_checked_ff <= 1'b1;
                  rsp_outlier_ff <= outlier;
                  rsp_center_ff  <= win_ff[CENTER];
                  rsp_median_ff  <= median_key_ff ^ SIGN_FLIP;
                  rsp_mad_ff     <= mad_ff;
                  if (!outlier && win_ff[CENTER] != accepted_ff) begin
                     accepted_ff      <= win_ff[CENTER];
                     rsp_published_ff <= win_ff[CENTER];
                     rsp_updated_ff   <= 1'b1;
                  end else begin
                     rsp_published_ff <= accepted_ff;
                     rsp_updated_ff   <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.checked              = rsp_checked_ff;
   assign rsp_chan.is_outlier           = rsp_outlier_ff;
   assign rsp_chan.center_value         = rsp_center_ff;
   assign rsp_chan.window_median        = rsp_median_ff;
   assign rsp_chan.abs_deviation_median = rsp_mad_ff;
   assign rsp_chan.published_value      = rsp_published_ff;
   assign rsp_chan.updated              = rsp_updated_ff;

endmodule

`default_nettype wire

### hdl/hof_checker.sv
// Port-level checks of the Hampel outlier filter, bound to the top level.
`default_nettype none

module hof_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        checked,
   input wire logic        is_outlier,
   input wire logic        updated,
   input wire logic [31:0] center_value,
   input wire logic [31:0] published_value
);

   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(published_value)
         && $stable(center_value))
      else $error("result changed while stalled");

   // A result is pending only after reset has been released.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // An update publishes the tested center, which passed the test.
   a_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && updated |-> checked && !is_outlier && published_value == center_value)
      else $error("update inconsistent with test");

   // Only a made test can flag an outlier.
   a_outlier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_outlier |-> checked && !updated)
      else $error("outlier without test");

endmodule

bind hampel_outlier_filter hof_checker u_hof_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .checked         (rsp_chan.checked),
   .is_outlier      (rsp_chan.is_outlier),
   .updated         (rsp_chan.updated),
   .center_value    (rsp_chan.center_value),
   .published_value (rsp_chan.published_value)
);

`default_nettype wire

### test/hampel_outlier_filter_tb.sv
// Self-checking testbench of the Hampel outlier filter: random and directed readings.
`default_nettype none

module hampel_outlier_filter_tb;
   import hof_pkg::*;

   localparam int WIN = WINDOW_DEFAULT;
   localparam int MID = WIN / 2;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        checked;
      logic        is_outlier;
      logic [31:0] center_value;
      logic [31:0] window_median;
      logic [31:0] abs_deviation_median;
      logic [31:0] published_value;
      logic        updated;
   } verdict_type;

   // Scoreboard: tracks the window state and queues the expected verdicts.
   class hampel_scoreboard;
      logic [31:0] samples[WIN];
      int          filled;
      logic [31:0] published;
      logic [15:0] scale;
      verdict_type pending[$];
      int          errors;

      function new();
         filled = 0;
         published = '0;
         scale = SCALE_RESET;
         errors = 0;
      endfunction

      // Rank selection of the middle key, on sign-flipped readings or on deviations.
      function logic [31:0] rank_mid(logic [31:0] k[WIN]);
         logic [31:0] t;
         for (int i = 1; i < WIN; i++)
            for (int j = i; j > 0 && k[j-1] > k[j]; j--) begin
               t = k[j]; k[j] = k[j-1]; k[j-1] = t;
            end
         return k[MID];
      endfunction

      function void note_reading(logic [31:0] rd);
         verdict_type v;
         logic [31:0] k[WIN];
         logic [31:0] med_key, mad, dev;
         v = '0;
         if (filled < WIN) begin
            samples[filled] = rd;
            filled++;
         end else begin
            for (int i = 0; i < WIN - 1; i++) samples[i] = samples[i+1];
            samples[WIN-1] = rd;
            for (int i = 0; i < WIN; i++) k[i] = samples[i] ^ SIGN_FLIP;
            med_key = rank_mid(k);
            for (int i = 0; i < WIN; i++)
               k[i] = (k[i] > med_key) ? k[i] - med_key : med_key - k[i];
            for (int i = 0; i < WIN; i++)
               k[i] = ((samples[i] ^ SIGN_FLIP) > med_key) ?
                      (samples[i] ^ SIGN_FLIP) - med_key : med_key - (samples[i] ^ SIGN_FLIP);
            mad = rank_mid(k);
            dev = ((samples[MID] ^ SIGN_FLIP) > med_key) ?
                  (samples[MID] ^ SIGN_FLIP) - med_key : med_key - (samples[MID] ^ SIGN_FLIP);
            v.checked = 1'b1;
            v.is_outlier = ({24'd0, dev, 8'd0} > 64'(scale) * 64'(mad));
            v.center_value = samples[MID];
            v.window_median = med_key ^ SIGN_FLIP;
            v.abs_deviation_median = mad;
            if (!v.is_outlier && samples[MID] != published) begin
               published = samples[MID];
               v.updated = 1'b1;
            end
         end
         v.published_value = published;
         pending.push_back(v);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type exp_v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_v = pending.pop_front();
         if (got.checked !== exp_v.checked)
            $display("%0t: checked exp %h got %h", $time, exp_v.checked, got.checked);
         if (got.is_outlier !== exp_v.is_outlier)
            $display("%0t: is_outlier exp %h got %h", $time, exp_v.is_outlier, got.is_outlier);
         if (got.center_value !== exp_v.center_value)
            $display("%0t: center_value exp %h got %h", $time,
                     exp_v.center_value, got.center_value);
         if (got.window_median !== exp_v.window_median)
            $display("%0t: window_median exp %h got %h", $time,
                     exp_v.window_median, got.window_median);
         if (got.abs_deviation_median !== exp_v.abs_deviation_median)
            $display("%0t: abs_deviation_median exp %h got %h", $time,
                     exp_v.abs_deviation_median, got.abs_deviation_median);
         if (got.published_value !== exp_v.published_value)
            $display("%0t: published_value exp %h got %h", $time,
                     exp_v.published_value, got.published_value);
         if (got.updated !== exp_v.updated)
            $display("%0t: updated exp %h got %h", $time, exp_v.updated, got.updated);
         if (got !== exp_v) errors++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [0:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   bit          idle_on = 1'b1;
   int          cycle_count = 0;

   hof_req_if req_chan ();
   hof_rsp_if rsp_chan ();

   hampel_scoreboard board = new();

   hampel_outlier_filter dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.reading = '0;
      rsp_chan.ready = 1'b0;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stalls, check each transfer.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_verdict({rsp_chan.checked, rsp_chan.is_outlier, rsp_chan.center_value,
                              rsp_chan.window_median, rsp_chan.abs_deviation_median,
                              rsp_chan.published_value, rsp_chan.updated});
      rsp_chan.ready <= !(idle_on && $urandom_range(99) < 37);
   end

   // Send one reading, with an optional random gap before it. Valid stays high
   // after the transfer until the next gap or a drain lowers it.
   task automatic send_reading(logic [31:0] rd);
      while (idle_on && $urandom_range(99) < 37) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.reading <= rd;
      do @(posedge clock); while (!req_chan.ready);
      board.note_reading(rd);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_scale(logic [31:0] val);
      drain();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1;
      csr_paddr <= REG_THRESHOLD_SCALE; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.scale = val[15:0];
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Mostly a smooth meter trend, with spikes and full-range noise.
   function automatic logic [31:0] pick_reading(ref logic [31:0] base);
      int sel;
      sel = $urandom_range(99);
      base = base + $urandom_range(40) - 20;
      if (sel < 70) return base;
      if (sel < 80) return base + $urandom_range(20000) - 10000;
      if (sel < 85) return base + $urandom_range(3) - 1;
      if (sel < 90) return sel[0] ? 32'h7fff_ffff : 32'h8000_0000;
      return $urandom();
   endfunction

   initial begin
      logic [31:0] base;
      logic [15:0] scales[5];
      scales = '{16'd1, 16'hffff, 16'd256, 16'd0, 16'd1139};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, constant window (zero MAD), single spike.
      send_reading(32'h7fff_ffff);
      send_reading(32'h8000_0000);
      send_reading(32'h0);
      send_reading(32'hffff_ffff);
      for (int i = 0; i < 14; i++) send_reading(32'd500);
      send_reading(32'd90000);
      for (int i = 0; i < 5; i++) send_reading(32'd500);

      base = $urandom();
      foreach (scales[s]) begin
         write_scale({16'($urandom_range(65535)), scales[s]});
         for (int i = 0; i < 280; i++) begin
            if (s == 2 && i == 100) drain();
            if (s == 1 && i == 40) idle_on = 1'b0;
            if (s == 1 && i == 200) idle_on = 1'b1;
            send_reading(pick_reading(base));
         end
      end

      drain();
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
